[src/pcg_pkg.sv]
package pcg_pkg;

    localparam int unsigned LumaR    = 77;
    localparam int unsigned LumaG    = 150;
    localparam int unsigned LumaB    = 29;
    localparam int unsigned LumSumW  = 13;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 10;

    localparam logic [8:0] SatOne    = 9'd256;
    localparam logic [9:0] BrightOne = 10'd256;
    localparam logic [4:0] ChanMax   = 5'd31;

    typedef logic [4:0]        t_chan;
    typedef logic [8:0]        t_sat;
    typedef logic [9:0]        t_bright;
    typedef logic signed [6:0] t_tint;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SAT    = 3'd0,
        CFG_BRIGHT = 3'd1,
        CFG_TINT_R = 3'd2,
        CFG_TINT_G = 3'd3,
        CFG_TINT_B = 3'd4
    } t_cfg_idx;

endpackage

[src/palette_color_grade.sv]
// Throughput: one item per cycle; four register stages (luma, saturation,
// brightness, tint/clamp) all advance together unless the output is stalled.
// Reset (synchronous, active low) empties the pipeline and restores
// saturation 256, brightness 256 and all tints 0.
module palette_color_grade
    import pcg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [15:0]         i_color_in,
    input  logic [3:0]          i_entry_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [15:0]         o_color_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic                en;
    logic                dark;
    t_chan               c_r, c_g, c_b;
    logic [LumSumW-1:0]  lum_sum;
    t_sat                sat_eff;
    t_chan               q_r, q_g, q_b;

    t_sat    r_sat;
    t_bright r_bright;
    t_tint   r_tint_r, r_tint_g, r_tint_b;

    logic        r_v1, r_v2, r_v3, r_v4;
    logic        r_pass1, r_pass2, r_pass3, r_pass4;
    logic [15:0] r_col1, r_col2, r_col3, r_col4;
    t_chan       r_r1, r_g1, r_b1, r_lum1;

    assign en          = !(r_v4 && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_v4;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= SatOne;
            r_bright <= BrightOne;
            r_tint_r <= '0;
            r_tint_g <= '0;
            r_tint_b <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SAT:    r_sat    <= i_cfg_data[8:0];
                CFG_BRIGHT: r_bright <= i_cfg_data;
                CFG_TINT_R: r_tint_r <= i_cfg_data[6:0];
                CFG_TINT_G: r_tint_g <= i_cfg_data[6:0];
                CFG_TINT_B: r_tint_b <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign sat_eff = (r_sat > SatOne) ? SatOne : r_sat;

    always_comb begin
        dark    = i_color_in[15];
        c_r     = {i_color_in[11:8], dark};
        c_g     = {i_color_in[7:4], dark};
        c_b     = {i_color_in[3:0], dark};
        lum_sum = LumSumW'(c_r) * LumSumW'(LumaR)
                + LumSumW'(c_g) * LumSumW'(LumaG)
                + LumSumW'(c_b) * LumSumW'(LumaB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pass1 <= (i_entry_index == 4'd0);
            r_col1  <= i_color_in;
            r_r1    <= c_r;
            r_g1    <= c_g;
            r_b1    <= c_b;
            r_lum1  <= lum_sum[LumSumW-1:8];
            r_pass2 <= r_pass1;
            r_col2  <= r_col1;
            r_pass3 <= r_pass2;
            r_col3  <= r_col2;
            r_pass4 <= r_pass3;
            r_col4  <= r_col3;
        end
    end

    pcg_chan u_chan_r (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_c      (r_r1),
        .i_lum    (r_lum1),
        .i_sat    (sat_eff),
        .i_bright (r_bright),
        .i_tint   (r_tint_r),
        .o_q      (q_r)
    );

    pcg_chan u_chan_g (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_c      (r_g1),
        .i_lum    (r_lum1),
        .i_sat    (sat_eff),
        .i_bright (r_bright),
        .i_tint   (r_tint_g),
        .o_q      (q_g)
    );

    pcg_chan u_chan_b (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_c      (r_b1),
        .i_lum    (r_lum1),
        .i_sat    (sat_eff),
        .i_bright (r_bright),
        .i_tint   (r_tint_b),
        .o_q      (q_b)
    );

    assign o_color_out = r_pass4 ? r_col4
                                 : {q_r[0], 3'b000, q_r[4:1], q_g[4:1], q_b[4:1]};

endmodule

[src/pcg_chan.sv]
module pcg_chan
    import pcg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_chan   i_c,
    input  t_chan   i_lum,
    input  t_sat    i_sat,
    input  t_bright i_bright,
    input  t_tint   i_tint,
    output t_chan   o_q
);

    logic signed [5:0]  diff;
    logic signed [15:0] prod;
    logic signed [15:0] prod_sh;
    logic signed [6:0]  v_full;
    logic [14:0]        bprod;
    logic signed [8:0]  sum;

    t_chan       r_v,  n_v;
    logic [6:0]  r_br, n_br;
    t_chan       r_q,  n_q;

    // saturation: lum + floor((c - lum) * sat / 256)
    always_comb begin
        diff    = $signed({1'b0, i_c}) - $signed({1'b0, i_lum});
        prod    = $signed(16'(diff)) * $signed(16'({1'b0, i_sat}));
        prod_sh = prod >>> 8;
        v_full  = $signed({2'b00, i_lum}) + $signed(prod_sh[6:0]);
        n_v     = v_full[4:0];
    end

    // brightness
    always_comb begin
        bprod = 15'(r_v) * 15'(i_bright);
        n_br  = bprod[14:8];
    end

    // tint and clamp
    always_comb begin
        sum = $signed({2'b00, r_br}) + $signed(9'(i_tint));
        priority if (sum < 0) begin
            n_q = '0;
        end else if (sum > $signed({4'b0000, ChanMax})) begin
            n_q = ChanMax;
        end else begin
            n_q = sum[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v  <= n_v;
            r_br <= n_br;
            r_q  <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[src/pcg_checker.sv]
module pcg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [15:0] i_color_in,
    input logic [3:0]  i_entry_index,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_color_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_color_out)))
        else $error("stalled output item changed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_entry_index == 4'd0))
        ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> (o_valid && (o_color_out == $past(i_color_in, 4))))
        else $error("entry zero item not passed through");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_entry_index != 4'd0))
        ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> (o_valid && (o_color_out[14:12] == 3'b000)))
        else $error("graded item missing or unused bits set");

endmodule

bind palette_color_grade pcg_checker u_pcg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_color_in    (i_color_in),
    .i_entry_index (i_entry_index),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_color_out   (o_color_out)
);
